[rtl/gna_pkg.sv]
// Shared constants, codes and the absolute-difference helper for the agent assigner.
package gna_pkg;

   localparam int COORD_W        = 24;
   localparam int MERGE_W        = 25;
   localparam int AGENT_FIELD_W  = 3;
   localparam int SQ_W           = 2 * COORD_W;
   localparam int DIST_W         = SQ_W + 1;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int AGENTS_DEFAULT = 3;

   localparam logic [MERGE_W-1:0] MERGE_RESET = MERGE_W'(4096);

   // transaction kinds
   localparam logic KIND_AGENT  = 1'b0;
   localparam logic KIND_TARGET = 1'b1;

   // register index taken from paddr above the byte offset
   localparam logic REG_MERGE = 1'b0;

   // |a - b| of two signed coordinates; always fits the coordinate width unsigned
   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

endpackage

[rtl/greedy_nearest_agent_assign.sv]
// Greedy nearest-agent assigner: target table, merge check and agent selection.
// Agent updates are taken while idle and never raise busy; they give no result.
// A target report holds busy through the merge scan of the stored targets, the decide step,
// the scan of the free agents (held agents are skipped) and the done state.
// rsp_strobe rises as busy falls; a new transaction can be taken in that cycle.
// Results cannot be stalled. Synchronous reset zeroes agents, empties the table, merge = 4096.
module greedy_nearest_agent_assign
   import gna_pkg::*;
#(
   parameter int AGENTS = AGENTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic [AGENT_FIELD_W-1:0]          req_agent,
   input  logic signed [COORD_W-1:0]         req_pos_x,
   input  logic signed [COORD_W-1:0]         req_pos_y,
   input  logic signed [COORD_W-1:0]         req_pos_z,
   output logic                              rsp_strobe,
   output logic signed [COORD_W-1:0]         rsp_goal_x,
   output logic signed [COORD_W-1:0]         rsp_goal_y,
   output logic signed [COORD_W-1:0]         rsp_goal_z,
   output logic [AGENT_FIELD_W-1:0]          rsp_assigned_agent,
   output logic [AGENT_FIELD_W-1:0]          rsp_target_slot,
   output logic                              rsp_added,
   output logic                              rsp_dropped,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [CSR_ADDR_W-1:0]             paddr,
   input  logic [CSR_DATA_W-1:0]             pwdata,
   output logic [CSR_DATA_W-1:0]             prdata,
   output logic                              pready
);

   localparam int AW = (AGENTS > 1) ? $clog2(AGENTS) : 1;
   localparam int CW = $clog2(AGENTS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MERGE  = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_ASSIGN = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam logic [1:0] PH_X   = 2'd0;
   localparam logic [1:0] PH_Y   = 2'd1;
   localparam logic [1:0] PH_SQ  = 2'd2;
   localparam logic [1:0] PH_CMP = 2'd3;

   logic [2:0]                state_ff, state_in;
   logic [1:0]                phase_ff, phase_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             slot_ff, slot_in;
   logic                      rep_ff, rep_in;
   logic                      added_ff, added_in;
   logic                      dropped_ff, dropped_in;
   logic                      have_ff, have_in;
   logic [AW-1:0]             best_ff, best_in;
   logic [DIST_W-1:0]         best_d_ff, best_d_in;
   logic [COORD_W-1:0]        d_ff, d_in;
   logic [SQ_W-1:0]           prod_ff, prod_in;
   logic [SQ_W-1:0]           acc_ff, acc_in;
   logic signed [COORD_W-1:0] lat_x_ff, lat_x_in;
   logic signed [COORD_W-1:0] lat_y_ff, lat_y_in;
   logic signed [COORD_W-1:0] lat_z_ff, lat_z_in;
   logic [MERGE_W-1:0]        merge_ff;

   logic signed [COORD_W-1:0] agent_x_ff  [AGENTS];
   logic signed [COORD_W-1:0] agent_y_ff  [AGENTS];
   logic signed [COORD_W-1:0] target_x_ff [AGENTS];
   logic signed [COORD_W-1:0] target_y_ff [AGENTS];
   logic signed [COORD_W-1:0] target_z_ff [AGENTS];
   logic [AW-1:0]             owner_ff    [AGENTS];

   logic                      rsp_strobe_ff;
   logic signed [COORD_W-1:0] rsp_goal_x_ff, rsp_goal_y_ff, rsp_goal_z_ff;
   logic [AGENT_FIELD_W-1:0]  rsp_agent_ff, rsp_slot_ff;
   logic                      rsp_added_ff, rsp_dropped_ff;

   logic                      agent_we, target_we, owner_we, emit;
   logic [AW-1:0]             aidx, tidx;
   logic [AGENTS-1:0]         held;
   logic signed [COORD_W-1:0] diff_a, diff_b;
   logic [COORD_W-1:0]        diff;
   logic [SQ_W-1:0]           sq;
   logic [MERGE_W-1:0]        msum;
   logic [DIST_W-1:0]         cand_dist;
   logic [CW-1:0]             count_dec;
   logic [AW-1:0]             slot_last;
   logic                      csr_wr;

   assign aidx = idx_ff[AW-1:0];
   assign tidx = (state_ff == ST_MERGE) ? idx_ff[AW-1:0] : slot_ff;

   // shared arithmetic
   assign diff      = abs_diff(diff_a, diff_b);
   assign sq        = d_ff * d_ff;
   assign msum      = MERGE_W'(acc_ff[COORD_W-1:0]) + MERGE_W'(d_ff);
   assign cand_dist = DIST_W'(acc_ff) + DIST_W'(prod_ff);
   assign count_dec = count_ff - CW'(1);
   assign slot_last = count_dec[AW-1:0];

   // agents held by earlier targets
   always_comb begin
      held = '0;
      for (int j = 0; j < AGENTS; j++) begin
         for (int a = 0; a < AGENTS; a++) begin
            if ((AW'(j) < slot_ff) && (owner_ff[j] == AW'(a))) begin
               held[a] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (state_ff == ST_MERGE) begin
         diff_a = (phase_ff == PH_X) ? target_x_ff[tidx] : target_y_ff[tidx];
         diff_b = (phase_ff == PH_X) ? lat_x_ff : lat_y_ff;
      end else begin
         diff_a = (phase_ff == PH_X) ? agent_x_ff[aidx] : agent_y_ff[aidx];
         diff_b = (phase_ff == PH_X) ? target_x_ff[tidx] : target_y_ff[tidx];
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      rep_in     = rep_ff;
      added_in   = added_ff;
      dropped_in = dropped_ff;
      have_in    = have_ff;
      best_in    = best_ff;
      best_d_in  = best_d_ff;
      d_in       = d_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      lat_x_in   = lat_x_ff;
      lat_y_in   = lat_y_ff;
      lat_z_in   = lat_z_ff;
      agent_we   = 1'b0;
      target_we  = 1'b0;
      owner_we   = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_TARGET) begin
                  lat_x_in = req_pos_x;
                  lat_y_in = req_pos_y;
                  lat_z_in = req_pos_z;
                  idx_in   = '0;
                  phase_in = PH_X;
                  rep_in   = 1'b0;
                  state_in = ST_MERGE;
               end else if ({1'b0, req_agent} < (AGENT_FIELD_W + 1)'(AGENTS)) begin
                  agent_we = 1'b1;
               end
            end
         end
         ST_MERGE: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DECIDE;
            end else begin
               case (phase_ff)
                  PH_X: begin
                     d_in     = diff;
                     phase_in = PH_Y;
                  end
                  PH_Y: begin
                     d_in     = diff;
                     acc_in   = SQ_W'(d_ff);
                     phase_in = PH_SQ;
                  end
                  default: begin
                     if (msum < merge_ff) begin
                        rep_in   = 1'b1;
                        state_in = ST_DECIDE;
                     end else begin
                        idx_in   = idx_ff + CW'(1);
                        phase_in = PH_X;
                     end
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            added_in   = 1'b0;
            dropped_in = 1'b0;
            slot_in    = slot_last;
            idx_in     = '0;
            phase_in   = PH_X;
            have_in    = 1'b0;
            state_in   = ST_ASSIGN;
            if (!rep_ff) begin
               if (count_ff < CW'(AGENTS)) begin
                  target_we = 1'b1;
                  count_in  = count_ff + CW'(1);
                  added_in  = 1'b1;
                  slot_in   = count_ff[AW-1:0];
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         ST_ASSIGN: begin
            if (idx_ff == CW'(AGENTS)) begin
               state_in = ST_DONE;
            end else begin
               case (phase_ff)
                  PH_X: begin
                     if (held[aidx]) begin
                        idx_in = idx_ff + CW'(1);
                     end else begin
                        d_in     = diff;
                        phase_in = PH_Y;
                     end
                  end
                  PH_Y: begin
                     d_in     = diff;
                     prod_in  = sq;
                     phase_in = PH_SQ;
                  end
                  PH_SQ: begin
                     prod_in  = sq;
                     acc_in   = prod_ff;
                     phase_in = PH_CMP;
                  end
                  default: begin
                     // strict compare keeps the lower index on a tie
                     if (!have_ff || (cand_dist < best_d_ff)) begin
                        have_in   = 1'b1;
                        best_d_in = cand_dist;
                        best_in   = aidx;
                     end
                     idx_in   = idx_ff + CW'(1);
                     phase_in = PH_X;
                  end
               endcase
            end
         end
         ST_DONE: begin
            owner_we = 1'b1;
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MERGE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_X;
         idx_ff        <= '0;
         count_ff      <= '0;
         have_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         merge_ff      <= MERGE_RESET;
         for (int i = 0; i < AGENTS; i++) begin
            agent_x_ff[i] <= '0;
            agent_y_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         have_ff       <= have_in;
         rsp_strobe_ff <= emit;
         if (csr_wr) begin
            merge_ff <= pwdata[MERGE_W-1:0];
         end
         if (agent_we) begin
            agent_x_ff[req_agent[AW-1:0]] <= req_pos_x;
            agent_y_ff[req_agent[AW-1:0]] <= req_pos_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      rep_ff     <= rep_in;
      added_ff   <= added_in;
      dropped_ff <= dropped_in;
      best_ff    <= best_in;
      best_d_ff  <= best_d_in;
      d_ff       <= d_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      lat_x_ff   <= lat_x_in;
      lat_y_ff   <= lat_y_in;
      lat_z_ff   <= lat_z_in;
      if (target_we) begin
         target_x_ff[count_ff[AW-1:0]] <= lat_x_ff;
         target_y_ff[count_ff[AW-1:0]] <= lat_y_ff;
         target_z_ff[count_ff[AW-1:0]] <= lat_z_ff;
      end
      if (owner_we) begin
         owner_ff[slot_ff] <= best_ff;
      end
      if (emit) begin
         rsp_goal_x_ff  <= target_x_ff[tidx];
         rsp_goal_y_ff  <= target_y_ff[tidx];
         rsp_goal_z_ff  <= target_z_ff[tidx];
         rsp_agent_ff   <= AGENT_FIELD_W'(best_ff);
         rsp_slot_ff    <= AGENT_FIELD_W'(slot_ff);
         rsp_added_ff   <= added_ff;
         rsp_dropped_ff <= dropped_ff;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_goal_x         = rsp_goal_x_ff;
   assign rsp_goal_y         = rsp_goal_y_ff;
   assign rsp_goal_z         = rsp_goal_z_ff;
   assign rsp_assigned_agent = rsp_agent_ff;
   assign rsp_target_slot    = rsp_slot_ff;
   assign rsp_added          = rsp_added_ff;
   assign rsp_dropped        = rsp_dropped_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MERGE) ? CSR_DATA_W'(merge_ff) : '0;

endmodule

[tb/tb_greedy_nearest_agent_assign.sv]
// Self-checking testbench for the greedy nearest-agent assigner: directed and random phases.
`timescale 1ns / 100ps

module tb_greedy_nearest_agent_assign
   import gna_pkg::*;
();

   localparam int AGENTS        = AGENTS_DEFAULT;
   localparam int SETTLE_CYCLES = 7 * AGENTS + 3 + 6;
   localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(-(1 <<< (COORD_W - 1)));
   localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'((1 <<< (COORD_W - 1)) - 1);
   localparam logic [MERGE_W-1:0] MERGE_MAX = '1;
   localparam logic [CSR_ADDR_W-1:0] MERGE_ADDR = {REG_MERGE, 2'b00};

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [AGENT_FIELD_W-1:0]  agent;
      logic [AGENT_FIELD_W-1:0]  slot;
      logic                      added;
      logic                      dropped;
   } goal_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic req_kind;
   logic [AGENT_FIELD_W-1:0] req_agent;
   logic signed [COORD_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic rsp_strobe;
   logic signed [COORD_W-1:0] rsp_goal_x, rsp_goal_y, rsp_goal_z;
   logic [AGENT_FIELD_W-1:0] rsp_assigned_agent, rsp_target_slot;
   logic rsp_added, rsp_dropped;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;
   logic pready;

   greedy_nearest_agent_assign #(.AGENTS(AGENTS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_agent(req_agent),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_strobe(rsp_strobe), .rsp_goal_x(rsp_goal_x), .rsp_goal_y(rsp_goal_y),
      .rsp_goal_z(rsp_goal_z), .rsp_assigned_agent(rsp_assigned_agent),
      .rsp_target_slot(rsp_target_slot), .rsp_added(rsp_added), .rsp_dropped(rsp_dropped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic signed [COORD_W-1:0] fleet_x [AGENTS];
   logic signed [COORD_W-1:0] fleet_y [AGENTS];
   logic signed [COORD_W-1:0] goal_tab_x [AGENTS];
   logic signed [COORD_W-1:0] goal_tab_y [AGENTS];
   logic signed [COORD_W-1:0] goal_tab_z [AGENTS];
   int unsigned goal_owner [AGENTS];
   int unsigned goal_count;
   logic [MERGE_W-1:0] merge_thresh;

   goal_type pending_goals [$];
   int mismatches = 0;
   int n_reports = 0, n_added = 0, n_dropped = 0, n_updates = 0, n_ignored = 0;
   bit steady = 0;

   function automatic longint abs_gap(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
   endfunction

   // Store or merge the report, then hand the newest target to the nearest free agent.
   function automatic goal_type assign_goal(logic signed [COORD_W-1:0] x,
                                            logic signed [COORD_W-1:0] y,
                                            logic signed [COORD_W-1:0] z);
      goal_type g;
      bit repeats;
      bit have;
      bit held [AGENTS];
      int unsigned slot;
      int unsigned best;
      longint best_d;
      longint d;
      repeats = 0;
      for (int i = 0; i < goal_count; i++)
         if (abs_gap(goal_tab_x[i], x) + abs_gap(goal_tab_y[i], y) < longint'(merge_thresh))
            repeats = 1;
      g.added = 1'b0;
      g.dropped = 1'b0;
      if (!repeats) begin
         if (goal_count < AGENTS) begin
            goal_tab_x[goal_count] = x;
            goal_tab_y[goal_count] = y;
            goal_tab_z[goal_count] = z;
            goal_count++;
            g.added = 1'b1;
         end else begin
            g.dropped = 1'b1;
         end
      end
      slot = goal_count - 1;
      for (int i = 0; i < AGENTS; i++)
         held[i] = 0;
      for (int i = 0; i < slot; i++)
         held[goal_owner[i]] = 1;
      have = 0;
      best = 0;
      best_d = 0;
      for (int i = 0; i < AGENTS; i++) begin
         if (!held[i]) begin
            d = abs_gap(fleet_x[i], goal_tab_x[slot]) ** 2
              + abs_gap(fleet_y[i], goal_tab_y[slot]) ** 2;
            if (!have || d < best_d) begin
               have = 1;
               best_d = d;
               best = i;
            end
         end
      end
      goal_owner[slot] = best;
      g.x = goal_tab_x[slot];
      g.y = goal_tab_y[slot];
      g.z = goal_tab_z[slot];
      g.agent = best[AGENT_FIELD_W-1:0];
      g.slot = slot[AGENT_FIELD_W-1:0];
      return g;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // compare every result against the oldest outstanding target
   always @(posedge clock) begin
      goal_type g;
      if (!reset && rsp_strobe) begin
         if (pending_goals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no transaction outstanding", $time);
         end else begin
            g = pending_goals.pop_front();
            check_field("goal_x", g.x, rsp_goal_x);
            check_field("goal_y", g.y, rsp_goal_y);
            check_field("goal_z", g.z, rsp_goal_z);
            check_field("assigned_agent", g.agent, rsp_assigned_agent);
            check_field("target_slot", g.slot, rsp_target_slot);
            check_field("added", g.added, rsp_added);
            check_field("dropped", g.dropped, rsp_dropped);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Called at a rising edge; returns at the edge that accepts the transaction.
   task automatic send_item(logic kind, logic [AGENT_FIELD_W-1:0] agent,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z);
      int gap;
      goal_type g;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind <= kind;
      req_agent <= agent;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == KIND_TARGET) begin
         g = assign_goal(x, y, z);
         pending_goals.push_back(g);
         n_reports++;
         n_added += g.added;
         n_dropped += g.dropped;
      end else if (agent < AGENTS) begin
         fleet_x[agent] = x;
         fleet_y[agent] = y;
         n_updates++;
      end else begin
         n_ignored++;
      end
   endtask

   // Drop start and let every outstanding result arrive, plus the worst-case latency.
   task automatic settle();
      start <= 1'b0;
      for (int n = 0; n < 400 && pending_goals.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_xfer(logic write, logic [CSR_DATA_W-1:0] wdata,
                           output logic [CSR_DATA_W-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= MERGE_ADDR;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_merge();
      logic [CSR_DATA_W-1:0] rd;
      csr_xfer(1'b0, '0, rd);
      check_field("merge_distance readback", CSR_DATA_W'(merge_thresh), rd);
   endtask

   task automatic write_merge(logic [MERGE_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      settle();
      csr_xfer(1'b1, CSR_DATA_W'(value), rd);
      merge_thresh = value;
      read_merge();
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      int r;
      logic [31:0] w;
      r = $urandom_range(0, 9);
      w = $urandom;
      if (r == 0)
         return COORD_MIN;
      if (r == 1)
         return COORD_MAX;
      if (r < 5)
         return COORD_W'($urandom_range(0, 128) - 64);
      return w[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] base,
                                                            int span);
      longint v;
      v = longint'(base) + longint'($urandom_range(0, 2 * span)) - span;
      if (v < longint'(COORD_MIN))
         v = COORD_MIN;
      if (v > longint'(COORD_MAX))
         v = COORD_MAX;
      return v[COORD_W-1:0];
   endfunction

   // Mixed agent moves and reports; ignored updates do not count toward the total.
   task automatic run_random(int count, bit aim_near);
      int n;
      int s;
      int span;
      logic kind;
      logic [AGENT_FIELD_W-1:0] agent;
      logic signed [COORD_W-1:0] x, y;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 49) == 0)
            steady = !steady;
         kind = ($urandom_range(0, 99) < 40) ? KIND_TARGET : KIND_AGENT;
         agent = ($urandom_range(0, 4) == 0) ? AGENT_FIELD_W'($urandom_range(0, 7))
                                             : AGENT_FIELD_W'($urandom_range(0, AGENTS - 1));
         x = rand_coord();
         y = rand_coord();
         if (kind == KIND_TARGET && aim_near && goal_count > 0 && $urandom_range(0, 9) < 6) begin
            s = $urandom_range(0, goal_count - 1);
            span = $urandom_range(0, 1) ? 4096 : 65536;
            x = near_coord(goal_tab_x[s], span);
            y = near_coord(goal_tab_y[s], span);
         end
         send_item(kind, agent, x, y, rand_coord());
         if (!(kind == KIND_AGENT && agent >= AGENTS))
            n++;
      end
   endtask

   task automatic test_agent_positions();
      send_item(KIND_AGENT, 3'd7, COORD_MIN, COORD_MAX, COORD_MIN);
      send_item(KIND_AGENT, AGENT_FIELD_W'(AGENTS), COORD_MAX, COORD_MAX, COORD_MAX);
      send_item(KIND_AGENT, 3'd1, -24'sd256, 24'sd0, 24'sd0);
      send_item(KIND_AGENT, 3'd0, 24'sd256, 24'sd0, COORD_MAX);
      send_item(KIND_AGENT, 3'd2, COORD_MAX, COORD_MIN, 24'sd0);
   endtask

   task automatic test_first_target();
      // equal distance to agents 0 and 1: lower index wins
      send_item(KIND_TARGET, 3'd5, 24'sd0, 24'sd0, COORD_MIN);
      // just inside the merge distance: repeats the stored target
      send_item(KIND_TARGET, 3'd0, 24'sd4095, 24'sd0, COORD_MAX);
      send_item(KIND_TARGET, 3'd7, -24'sd4095, 24'sd0, 24'sd0);
      send_item(KIND_AGENT, 3'd0, -24'sd256, 24'sd0, 24'sd0);
      send_item(KIND_TARGET, 3'd2, 24'sd0, -24'sd4095, 24'sd1);
   endtask

   task automatic test_one_target_random();
      write_merge(MERGE_MAX);
      run_random(300, 0);
   endtask

   task automatic test_second_target();
      write_merge(MERGE_RESET);
      // exactly at the merge distance: stored as a new target
      send_item(KIND_TARGET, 3'd3, 24'sd4096, 24'sd0, -24'sd1);
      write_merge(MERGE_MAX);
      run_random(300, 0);
   endtask

   task automatic test_full_table();
      logic [MERGE_W-1:0] v;
      write_merge('0);
      send_item(KIND_TARGET, 3'd6, COORD_MAX, COORD_MAX, COORD_MAX);
      // table full: refuse the new target, still reassign the newest
      send_item(KIND_TARGET, 3'd1, COORD_MIN, COORD_MIN, COORD_MIN);
      write_merge(MERGE_MAX);
      send_item(KIND_TARGET, 3'd4, COORD_MAX, COORD_MAX - 24'sd1, 24'sd0);
      for (int round = 0; round < 5; round++) begin
         if (round == 0)
            v = '0;
         else if (round == 1)
            v = MERGE_MAX;
         else if (round == 2)
            v = MERGE_W'($urandom_range(0, 65536));
         else
            v = MERGE_W'($urandom);
         write_merge(v);
         run_random(60, 1);
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= KIND_AGENT;
      req_agent <= '0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      for (int i = 0; i < AGENTS; i++) begin
         fleet_x[i] = '0;
         fleet_y[i] = '0;
         goal_tab_x[i] = '0;
         goal_tab_y[i] = '0;
         goal_tab_z[i] = '0;
         goal_owner[i] = 0;
      end
      goal_count = 0;
      merge_thresh = MERGE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      read_merge();
      test_agent_positions();
      test_first_target();
      test_one_target_random();
      test_second_target();
      test_full_table();

      settle();
      if (pending_goals.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", pending_goals.size());
      end
      $display("Covered %0d target reports (%0d stored, %0d refused on a full table),",
               n_reports, n_added, n_dropped);
      $display("%0d agent moves and %0d out-of-range moves; %0d mismatches.",
               n_updates, n_ignored, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
